>>> rtl/core/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg: shared types and constants for the comment blanker
// Byte codes, lexer mode encoding, channel payloads and queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package ccb_pkg;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // byte codes the lexer reacts to
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // lexer modes
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_LINE   = 5'b00010,
    MODE_BLOCK  = 5'b00100,
    MODE_SQ     = 5'b01000,
    MODE_DQ     = 5'b10000
  } lex_mode_t;

  // source channel payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } src_item_t;

  // result channel payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } res_item_t;

  // one queue entry: the one or two result bytes one source byte causes
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       last;
  } cmd_t;

  // front to queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // queue head to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

>>> rtl/core/ccb_front.sv
// ----------------------------------------------------------------------------
// ccb_front: lexer front end
// Tracks the lexer mode and the held slash or star, and turns each source
// byte into zero, one or two result bytes pushed as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_front
  import ccb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_item_t src_data,
  input  wire logic      full,
  output push_t          push
);

  lex_mode_t mode;
  lex_mode_t mode_next;
  logic      held;
  logic      held_next;
  logic      accept;

  logic       pre_valid;
  logic [7:0] pre_byte;
  logic       run_plain;
  logic       pair_space;
  lex_mode_t  mode_p;
  logic       plain_valid;
  logic [7:0] plain_byte;
  logic [7:0] b;
  logic       last;

  assign b         = src_data.in_byte;
  assign last      = src_data.in_last;
  assign src_stall = full;
  assign accept    = src_valid && !full;

  always_comb begin
    pre_valid   = 1'b0;
    pre_byte    = CH_SPACE;
    run_plain   = 1'b1;
    pair_space  = 1'b0;
    mode_p      = mode;
    mode_next   = mode;
    held_next   = 1'b0;
    plain_valid = 1'b0;
    plain_byte  = b;

    // resolve a held byte against the new one
    if (held) begin
      if (mode == MODE_BLOCK) begin
        if (b == CH_SLASH) begin
          pair_space = 1'b1;
          run_plain  = 1'b0;
          mode_next  = MODE_NORMAL;
        end else begin
          pre_valid = 1'b1;
          pre_byte  = CH_SPACE;
        end
      end else begin
        mode_p    = MODE_NORMAL;
        mode_next = MODE_NORMAL;
        if (b == CH_STAR) begin
          pair_space = 1'b1;
          run_plain  = 1'b0;
          mode_next  = MODE_BLOCK;
        end else if (b == CH_SLASH) begin
          pair_space = 1'b1;
          run_plain  = 1'b0;
          mode_next  = MODE_LINE;
        end else begin
          pre_valid = 1'b1;
          pre_byte  = CH_SLASH;
        end
      end
    end

    // the new byte with nothing held
    if (run_plain) begin
      case (mode_p)
        MODE_LINE: begin
          plain_valid = 1'b1;
          if (b == CH_LF) begin
            mode_next = MODE_NORMAL;
          end else begin
            plain_byte = CH_SPACE;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_STAR && !last) begin
            held_next = 1'b1;
          end else begin
            plain_valid = 1'b1;
            if (b != CH_LF && b != CH_CR) begin
              plain_byte = CH_SPACE;
            end
          end
        end
        MODE_SQ: begin
          plain_valid = 1'b1;
          if (b == CH_SQUOTE) begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_DQ: begin
          plain_valid = 1'b1;
          if (b == CH_DQUOTE) begin
            mode_next = MODE_NORMAL;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (b == CH_SLASH && !last) begin
            held_next = 1'b1;
          end else begin
            plain_valid = 1'b1;
            if (b == CH_SQUOTE) begin
              mode_next = MODE_SQ;
            end else if (b == CH_DQUOTE) begin
              mode_next = MODE_DQ;
            end
          end
        end
      endcase
    end

    // end of text starts the next text fresh
    if (last) begin
      mode_next = MODE_NORMAL;
      held_next = 1'b0;
    end

    // pack the queue entry
    push.cmd.last = last;
    if (pair_space) begin
      push.cmd.byte0 = CH_SPACE;
      push.cmd.byte1 = CH_SPACE;
      push.cmd.two   = 1'b1;
    end else if (pre_valid && plain_valid) begin
      push.cmd.byte0 = pre_byte;
      push.cmd.byte1 = plain_byte;
      push.cmd.two   = 1'b1;
    end else begin
      push.cmd.byte0 = pre_valid ? pre_byte : plain_byte;
      push.cmd.byte1 = plain_byte;
      push.cmd.two   = 1'b0;
    end
    push.valid = accept && (pair_space || pre_valid || plain_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ccb_queue.sv
// ----------------------------------------------------------------------------
// ccb_queue: entry queue between front and back
// Small circular buffer of result entries; full stalls the front.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_queue
  import ccb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       full,
  output head_t      head,
  input  wire logic  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("count missed a push");

endmodule

`default_nettype wire

>>> rtl/core/ccb_back.sv
// ----------------------------------------------------------------------------
// ccb_back: result serializer
// Drains queue entries into the result register, one byte per transfer,
// taking two transfers for a two-byte entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_back
  import ccb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire head_t head,
  output logic       pop,
  output logic       res_valid,
  input  wire logic  res_stall,
  output res_item_t  res_data
);

  logic phase;
  logic load;

  assign load = !res_valid || !res_stall;
  assign pop  = load && head.valid && (!head.cmd.two || phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      res_valid <= head.valid;
      if (head.valid) begin
        phase <= head.cmd.two && !phase;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      res_data.out_byte <= phase ? head.cmd.byte1 : head.cmd.byte0;
      res_data.out_last <= head.cmd.last && (phase || !head.cmd.two);
    end
  end

  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head.valid && head.cmd.two))
    else $error("second byte pending without a two-byte head");

  a_pop_ends_entry: assert property (@(posedge clk) disable iff (rst)
    pop |=> !phase)
    else $error("phase left set after pop");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (phase == $past(phase)))
    else $error("serializer advanced while stalled");

endmodule

`default_nettype wire

>>> rtl/core/c_comment_blanker_core.sv
// ----------------------------------------------------------------------------
// c_comment_blanker_core: streaming C/C++ comment blanker
// Replaces comment bytes of a source text stream with spaces.
// ----------------------------------------------------------------------------
// Source text enters one byte per transfer on the src channel, with
// in_last on the final byte, and leaves on the res channel with every byte
// of a line or block comment, delimiters included, turned into a space;
// newlines end line comments and are kept, and newline and carriage return
// survive inside block comments. Quoted literals pass unchanged with no
// escape handling. A slash, or a star inside a block comment, is held back
// one byte to spot a two-byte delimiter, so a source byte gives zero, one
// or two result bytes; a held byte is flushed on in_last, and each text
// ends with exactly one result carrying out_last. The front end takes one
// source byte per cycle while the entry queue (QUEUE_DEPTH entries) has
// room; the result register sends one byte per cycle unless res_stall
// holds it, so sustained rate is one source byte per cycle when each byte
// gives at most one result, and a byte that gives two results needs two
// result transfers. A source byte passes the queue and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module c_comment_blanker_core
  import ccb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  // source text
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_item_t src_data,
  // blanked text
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_data
);

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  // lexer: mode tracking and held-byte lookahead
  ccb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .full      (full),
    .push      (push)
  );

  // decouples the lexer from result stalls
  ccb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // splits two-byte entries into single result transfers
  ccb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

>>> test/ccb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccb_checker: scoreboard for the comment blanker
// Watches both channels, predicts the blanked bytes of every source transfer
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module ccb_checker
  import ccb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  input  wire logic      src_stall,
  input  wire src_item_t src_data,
  input  wire logic      res_valid,
  input  wire logic      res_stall,
  input  wire res_item_t res_data,
  output int             err_count,
  output int             outstanding
);

  // predicted lexer state
  lex_mode_t  mode;
  logic       held;
  logic [7:0] step_bytes[$];
  res_item_t  blanked_q[$];

  initial begin
    err_count   = 0;
    outstanding = 0;
    mode        = MODE_NORMAL;
    held        = 1'b0;
  end

  // byte handling with nothing held back
  function automatic void lex_plain(logic [7:0] b, logic last);
    case (mode)
      MODE_LINE: begin
        if (b == CH_LF) begin
          mode = MODE_NORMAL;
          step_bytes.push_back(b);
        end else begin
          step_bytes.push_back(CH_SPACE);
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR && !last) held = 1'b1;
        else if (b == CH_LF || b == CH_CR) step_bytes.push_back(b);
        else step_bytes.push_back(CH_SPACE);
      end
      MODE_SQ: begin
        if (b == CH_SQUOTE) mode = MODE_NORMAL;
        step_bytes.push_back(b);
      end
      MODE_DQ: begin
        if (b == CH_DQUOTE) mode = MODE_NORMAL;
        step_bytes.push_back(b);
      end
      default: begin
        mode = MODE_NORMAL;
        if (b == CH_SLASH && !last) begin
          held = 1'b1;
        end else begin
          if (b == CH_SQUOTE) mode = MODE_SQ;
          else if (b == CH_DQUOTE) mode = MODE_DQ;
          step_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  // predict the results of one source transfer
  function automatic void blank_step(src_item_t it);
    logic [7:0] b;
    logic       last;
    b    = it.in_byte;
    last = it.in_last;
    step_bytes.delete();
    if (held) begin
      held = 1'b0;
      if (mode == MODE_BLOCK) begin
        if (b == CH_SLASH) begin
          step_bytes.push_back(CH_SPACE);
          step_bytes.push_back(CH_SPACE);
          mode = MODE_NORMAL;
        end else begin
          step_bytes.push_back(CH_SPACE);
          lex_plain(b, last);
        end
      end else begin
        mode = MODE_NORMAL;
        if (b == CH_STAR || b == CH_SLASH) begin
          step_bytes.push_back(CH_SPACE);
          step_bytes.push_back(CH_SPACE);
          mode = (b == CH_STAR) ? MODE_BLOCK : MODE_LINE;
        end else begin
          step_bytes.push_back(CH_SLASH);
          lex_plain(b, last);
        end
      end
    end else begin
      lex_plain(b, last);
    end
    foreach (step_bytes[i])
      blanked_q.push_back('{out_byte: step_bytes[i],
                            out_last: last && (i == step_bytes.size() - 1)});
    if (last) begin
      mode = MODE_NORMAL;
      held = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      mode = MODE_NORMAL;
      held = 1'b0;
      blanked_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (blanked_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual byte %h last %b",
                   $time, res_data.out_byte, res_data.out_last);
        end else begin
          want = blanked_q.pop_front();
          if (res_data.out_byte !== want.out_byte) begin
            err_count++;
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, res_data.out_byte);
          end
          if (res_data.out_last !== want.out_last) begin
            err_count++;
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.out_last, res_data.out_last);
          end
        end
      end
      if (src_valid && !src_stall)
        blank_step(src_data);
    end
    outstanding <= blanked_q.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the comment blanker core
// Sends a short directed text set and then random C-like texts with bursty
// source timing and a patterned result stall; the checker scores results.
// ----------------------------------------------------------------------------

module tb;
  import ccb_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int IDLE_LIMIT   = 5000;
  // random source bytes after the directed texts
  localparam int RANDOM_ITEMS = 1500;
  // source count at which the result side holds off for a long stretch
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_item_t src_data  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_data;

  int        err_count;
  int        outstanding;
  int        sent = 0;
  int        idle_cycles = 0;

  // whole source text plan, one entry per source transfer
  src_item_t text_plan[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  c_comment_blanker_core uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  ccb_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_data    (src_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  // append one byte; close marks the end of a text
  function automatic void add_raw(logic [7:0] b, bit close);
    text_plan.push_back('{in_byte: b, in_last: close});
  endfunction

  function automatic void add_text(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      add_raw(s[i], close && (i == s.len() - 1));
  endfunction

  // comment or literal body; the stop byte is swapped out so a line
  // comment or quoted literal stays open until its proper close
  function automatic void add_body(int len, logic [7:0] stop);
    string      palette;
    logic [7:0] b;
    palette = "ab */\n\015'\"x;";
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
      else b = palette[$urandom_range(0, palette.len() - 1)];
      if (b == stop) b = "a";
      add_raw(b, 1'b0);
    end
  endfunction

  // one random text: mostly well formed tokens, some noise and broken ones
  function automatic void add_random_text();
    int ntok;
    ntok = $urandom_range(1, 10);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1: add_text("x = (a + 1); ", 1'b0);
        2, 3: begin
          add_text("/*", 1'b0);
          add_body($urandom_range(0, 8), 8'h00);
          add_text("*/", 1'b0);
        end
        4: begin
          add_text("//", 1'b0);
          add_body($urandom_range(0, 8), CH_LF);
          add_raw(CH_LF, 1'b0);
        end
        5: begin
          add_raw(CH_SQUOTE, 1'b0);
          add_body($urandom_range(0, 4), CH_SQUOTE);
          add_raw(CH_SQUOTE, 1'b0);
        end
        6: begin
          add_raw(CH_DQUOTE, 1'b0);
          add_body($urandom_range(0, 8), CH_DQUOTE);
          add_raw(CH_DQUOTE, 1'b0);
        end
        7: repeat ($urandom_range(1, 4)) add_raw(8'($urandom_range(0, 255)), 1'b0);
        8: begin
          case ($urandom_range(0, 4))
            0: add_text("/", 1'b0);
            1: add_text("*", 1'b0);
            2: add_text("**/", 1'b0);
            3: add_text("*//", 1'b0);
            default: add_text("/ /", 1'b0);
          endcase
        end
        default: begin
          // broken: comment or literal left open
          if ($urandom_range(0, 1) == 1) add_text("/*", 1'b0);
          else add_raw(CH_DQUOTE, 1'b0);
          add_body($urandom_range(0, 6), 8'h00);
        end
      endcase
    end
    text_plan[text_plan.size() - 1].in_last = 1'b1;
  endfunction

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: stall pattern changes style every phase, plus one long
  // hold-off so the entry queue fills and the source side gets stalled
  initial begin : receiver
    int phase_left;
    int style;
    int hold_left;
    bit held_off;
    phase_left = 0;
    style      = 0;
    hold_left  = 0;
    held_off   = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (phase_left == 0) begin
        style      = $urandom_range(0, 3);
        phase_left = $urandom_range(32, 256);
      end
      phase_left--;
      if (!held_off && sent >= HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (style)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= (phase_left % 3 == 0);
        endcase
      end
      @(posedge clk);
    end
  end

  // source side and verdict
  initial begin : source
    int burst_left;
    int gap_left;
    int directed_len;

    // held slash with no delimiter, block close then slash, nul byte ends text
    add_text("/**//q", 1'b0);
    add_raw(8'h00, 1'b1);
    // line comment with a high byte, newline ends it, slash as last byte
    add_text("//", 1'b0);
    add_raw(8'hFF, 1'b0);
    add_text("\n/", 1'b1);
    // held star with no delimiter, carriage return kept, star as last byte
    add_text("/**\015*", 1'b1);
    // comment start inside single quotes, text ends inside the literal
    add_text("'/*", 1'b1);
    // line comment start inside double quotes
    add_text("\"//\"", 1'b1);
    directed_len = text_plan.size();
    while (text_plan.size() < directed_len + RANDOM_ITEMS)
      add_random_text();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    gap_left   = 0;
    while (sent < text_plan.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        src_valid <= 1'b0;
        @(posedge clk);
      end else begin
        // offer the next byte and hold it until the transfer happens
        src_valid <= 1'b1;
        src_data  <= text_plan[sent];
        do @(posedge clk); while (src_stall);
        sent++;
        burst_left--;
      end
    end
    src_valid <= 1'b0;

    // drain: outstanding is registered, so wait for an update before looking at it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
